// ===== rtl/pf3p_pkg.sv =====
// Package for the plane-from-three-points block: widths, status codes
// and the queue entry passed from the front end to the back end.
// No dependencies.
package pf3p_pkg;

  // coordinate format
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int NORM_FRAC = 30;
  localparam int NORM_W    = 32;

  // front end: differences, cross products, normal
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NVEC_W = PROD_W + 1;

  // back end: normal magnitude split into limbs for the wide multiplies
  localparam int NLIMB  = 3;
  localparam int LIMB_W = (PROD_W + NLIMB - 1) / NLIMB;
  localparam int MAGP_W = LIMB_W * NLIMB;
  localparam int ROW_W  = (NLIMB + 1) * LIMB_W;
  localparam int SQ_W   = 2 * MAGP_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int PC_W   = MAGP_W + COORD_W;
  localparam int DOT_W  = PC_W + 3;
  localparam int DMAG_W = DOT_W - 1;

  // dividers and square root
  localparam int NQ_W   = 2 * NORM_FRAC + 1;
  localparam int NREM_W = SUM_W + 1;
  localparam int RT_W   = NORM_FRAC + 1;
  localparam int SQT_W  = 2 * RT_W + 1;
  localparam int CDIV_W = DMAG_W + COORD_W;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_ORIGIN    = 2'd2
  } status_t;

  // one classified item: normal as sign/magnitude, first point likewise
  typedef struct packed {
    logic                          coll;
    logic [2:0]                    nneg;
    logic [2:0][MAGP_W-1:0]        nmag;
    logic [2:0]                    cneg;
    logic [2:0][COORD_W-1:0]       cmag;
  } item_t;

endpackage

// ===== rtl/pf3p_in_if.sv =====
// Input channel: one beat carries three points.
// Depends on pf3p_pkg.
interface pf3p_in_if import pf3p_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_W-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_W-1:0] p2_x, p2_y, p2_z;

  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, input ready);
  modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, output ready);
endinterface

// ===== rtl/pf3p_out_if.sv =====
// Output channel: one beat carries plane coefficients, unit normal, status.
// Depends on pf3p_pkg.
interface pf3p_out_if import pf3p_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coef_a, coef_b, coef_c;
  logic signed [NORM_W-1:0]  norm_x, norm_y, norm_z;
  logic [1:0]                status;

  modport source (output valid, coef_a, coef_b, coef_c, norm_x, norm_y, norm_z,
                  status, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, norm_x, norm_y, norm_z,
                  status, output ready);
endinterface

// ===== rtl/pf3p_front.sv =====
// Front end: takes point beats, forms the exact normal and classifies it.
// Depends on pf3p_pkg and pf3p_in_if.
module pf3p_front import pf3p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pf3p_in_if.sink     pts,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic en;
  logic f1_vld, f2_vld, f3_vld, f4_vld;
  logic signed [DIFF_W-1:0]  f1_u [3];
  logic signed [DIFF_W-1:0]  f1_v [3];
  logic signed [COORD_W-1:0] f1_c [3];
  logic signed [PROD_W-1:0]  f2_pa [3];
  logic signed [PROD_W-1:0]  f2_pb [3];
  logic signed [COORD_W-1:0] f2_c [3];
  logic signed [NVEC_W-1:0]  f3_n [3];
  logic signed [COORD_W-1:0] f3_c [3];
  item_t                     f4_item;
  logic signed [COORD_W-1:0] in_p0 [3];
  logic signed [COORD_W-1:0] in_p1 [3];
  logic signed [COORD_W-1:0] in_p2 [3];
  logic [NVEC_W-1:0]         nabs [3];
  logic [COORD_W-1:0]        cabs [3];

  // pipeline moves unless the last stage is blocked by a full queue
  assign en        = !f4_vld || !q_full;
  assign pts.ready = en;
  assign q_push    = f4_vld && !q_full;
  assign q_item    = f4_item;

  always_comb begin
    in_p0[0] = pts.p0_x; in_p0[1] = pts.p0_y; in_p0[2] = pts.p0_z;
    in_p1[0] = pts.p1_x; in_p1[1] = pts.p1_y; in_p1[2] = pts.p1_z;
    in_p2[0] = pts.p2_x; in_p2[1] = pts.p2_y; in_p2[2] = pts.p2_z;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
      f4_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= pts.valid;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
      f4_vld <= f3_vld;
    end
  end

  // edge vectors u = p2 - p1, v = p0 - p1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_u[i] <= DIFF_W'(in_p2[i]) - DIFF_W'(in_p1[i]);
        f1_v[i] <= DIFF_W'(in_p0[i]) - DIFF_W'(in_p1[i]);
        f1_c[i] <= in_p0[i];
      end
    end
  end

  // cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      f2_pa[0] <= f1_u[1] * f1_v[2];
      f2_pb[0] <= f1_u[2] * f1_v[1];
      f2_pa[1] <= f1_u[2] * f1_v[0];
      f2_pb[1] <= f1_u[0] * f1_v[2];
      f2_pa[2] <= f1_u[0] * f1_v[1];
      f2_pb[2] <= f1_u[1] * f1_v[0];
      f2_c     <= f1_c;
    end
  end

  // normal components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f3_n[i] <= NVEC_W'(f2_pa[i]) - NVEC_W'(f2_pb[i]);
      end
      f3_c <= f2_c;
    end
  end

  // sign/magnitude split and collinear check
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nabs[i] = f3_n[i][NVEC_W-1] ? NVEC_W'(-f3_n[i]) : NVEC_W'(f3_n[i]);
      cabs[i] = f3_c[i][COORD_W-1] ? COORD_W'(-f3_c[i]) : COORD_W'(f3_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f4_item.nneg[i] <= f3_n[i][NVEC_W-1];
        f4_item.nmag[i] <= MAGP_W'(nabs[i]);
        f4_item.cneg[i] <= f3_c[i][COORD_W-1];
        f4_item.cmag[i] <= cabs[i];
      end
      f4_item.coll <= (f3_n[0] == '0) && (f3_n[1] == '0) && (f3_n[2] == '0);
    end
  end

endmodule

// ===== rtl/pf3p_fifo.sv =====
// Short register queue between the front end and the back end.
// Depends on pf3p_pkg.
module pf3p_fifo import pf3p_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t rdata
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   cnt;

  assign full     = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign nonempty = (cnt != '0);
  assign rdata    = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== rtl/pf3p_back.sv =====
// Back end: squares and dot product in limbs, then pipelined dividers and
// square root, then saturation and the output register.
// Depends on pf3p_pkg and pf3p_out_if.
module pf3p_back import pf3p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  item_t      q_head,
  output logic       q_pop,
  pf3p_out_if.source plane
);

  localparam int SD_LEN = NQ_W + RT_W;
  localparam int CF_LEN = NQ_W + RT_W - COORD_W;

  logic en;

  // front stages
  logic [5:0] vld;
  item_t      s0;
  logic [2*LIMB_W-1:0]        s1_sqp [3][NLIMB][NLIMB];
  logic [LIMB_W+COORD_W-1:0]  s1_pcp [3][NLIMB];
  logic [2:0]                 s1_nneg, s1_pneg;
  logic [2:0][MAGP_W-1:0]     s1_nmag;
  logic                       s1_coll;
  logic [ROW_W-1:0]           row [3][NLIMB];
  logic [PC_W-1:0]            pc [3];
  logic [ROW_W-1:0]           s2_row [3][NLIMB];
  logic [PC_W-1:0]            s2_pc [3];
  logic [2:0]                 s2_nneg, s2_pneg;
  logic [2:0][MAGP_W-1:0]     s2_nmag;
  logic                       s2_coll;
  logic [SQ_W-1:0]            sqc [3];
  logic [SQ_W-1:0]            s3_sq [3];
  logic signed [DOT_W-1:0]    s3_spc [3];
  logic [2:0]                 s3_nneg;
  logic [2:0][MAGP_W-1:0]     s3_nmag;
  logic                       s3_coll;
  logic [SQ_W-1:0]            s4_sq [3];
  logic [SUM_W-1:0]           s4_sum;
  logic signed [DOT_W-1:0]    s4_dot;
  logic [2:0]                 s4_nneg;
  logic [2:0][MAGP_W-1:0]     s4_nmag;
  logic                       s4_coll;
  logic [SQ_W-1:0]            s5_sq [3];
  logic [SUM_W-1:0]           s5_sum;
  logic [DMAG_W-1:0]          s5_dmag;
  logic                       s5_dneg, s5_dotz;
  logic [2:0]                 s5_nneg;
  logic [2:0][MAGP_W-1:0]     s5_nmag;
  logic                       s5_coll;

  // divider and root chains
  logic [NREM_W-1:0]  nd_r [1:NQ_W][3];
  logic [NQ_W-1:0]    nd_q [1:NQ_W][3];
  logic [SUM_W-1:0]   nd_d [1:NQ_W];
  logic [NQ_W-1:0]    rt_rem  [1:RT_W][3];
  logic [RT_W-1:0]    rt_root [1:RT_W][3];
  logic [CDIV_W-1:0]  cd_r [1:COORD_W][3];
  logic [COORD_W-1:0] cd_q [1:COORD_W][3];
  logic [DMAG_W-1:0]  cd_d [1:COORD_W];
  logic [2:0]         cd_ovf  [1:COORD_W];
  logic [2:0]         cd_nneg [1:COORD_W];
  logic               cd_dneg [1:COORD_W];

  // coefficient result and sideband delay lines
  logic [2:0][COORD_W-1:0] cf_new;
  logic [2:0][COORD_W-1:0] cf_dly [0:CF_LEN-1];
  logic [SD_LEN:1]         sd_vld;
  logic [2:0]              sd_nneg [1:SD_LEN];
  logic                    sd_coll [1:SD_LEN];
  logic                    sd_dotz [1:SD_LEN];

  logic [COORD_W-1:0] lim [3];
  logic [COORD_W-1:0] qv [3];
  logic               cneg [3];
  logic [NORM_W-1:0]  nm [3];
  logic [NORM_W-1:0]  nout [3];
  logic [COORD_W-1:0] cout [3];
  status_t            st;

  // whole back end advances when the output register can take a beat
  assign en    = !plane.valid || plane.ready;
  assign q_pop = en && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], q_nonempty};
    end
  end

  // stage 0: queue head
  always_ff @(posedge clk) begin
    if (en) s0 <= q_head;
  end

  // stage 1: limb partial products for |n|^2 and |n|*|p0|
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < NLIMB; j++) begin
          for (int k = 0; k < NLIMB; k++) begin
            s1_sqp[i][j][k] <= s0.nmag[i][j*LIMB_W +: LIMB_W]
                             * s0.nmag[i][k*LIMB_W +: LIMB_W];
          end
          s1_pcp[i][j] <= s0.nmag[i][j*LIMB_W +: LIMB_W] * s0.cmag[i];
        end
      end
      s1_nneg <= s0.nneg;
      s1_pneg <= s0.nneg ^ s0.cneg;
      s1_nmag <= s0.nmag;
      s1_coll <= s0.coll;
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        row[i][j] = '0;
        for (int k = 0; k < NLIMB; k++) begin
          row[i][j] = row[i][j] + (ROW_W'(s1_sqp[i][j][k]) << (LIMB_W * k));
        end
        pc[i] = pc[i] + (PC_W'(s1_pcp[i][j]) << (LIMB_W * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row  <= row;
      s2_pc   <= pc;
      s2_nneg <= s1_nneg;
      s2_pneg <= s1_pneg;
      s2_nmag <= s1_nmag;
      s2_coll <= s1_coll;
    end
  end

  // stage 3: squares, signed dot terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqc[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        sqc[i] = sqc[i] + (SQ_W'(s2_row[i][j]) << (LIMB_W * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_sq[i]  <= sqc[i];
        s3_spc[i] <= s2_pneg[i] ? -$signed(DOT_W'(s2_pc[i])) : $signed(DOT_W'(s2_pc[i]));
      end
      s3_nneg <= s2_nneg;
      s3_nmag <= s2_nmag;
      s3_coll <= s2_coll;
    end
  end

  // stage 4: |n|^2 and dot(n, p0)
  always_ff @(posedge clk) begin
    if (en) begin
      s4_sq   <= s3_sq;
      s4_sum  <= SUM_W'(s3_sq[0]) + SUM_W'(s3_sq[1]) + SUM_W'(s3_sq[2]);
      s4_dot  <= s3_spc[0] + s3_spc[1] + s3_spc[2];
      s4_nneg <= s3_nneg;
      s4_nmag <= s3_nmag;
      s4_coll <= s3_coll;
    end
  end

  // stage 5: dot sign/magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq   <= s4_sq;
      s5_sum  <= s4_sum;
      s5_dneg <= s4_dot[DOT_W-1];
      s5_dmag <= s4_dot[DOT_W-1] ? DMAG_W'(-s4_dot) : DMAG_W'(s4_dot);
      s5_dotz <= (s4_dot == '0);
      s5_nneg <= s4_nneg;
      s5_nmag <= s4_nmag;
      s5_coll <= s4_coll;
    end
  end

  // normal divider: floor(n_i^2 * 2^(2*NORM_FRAC) / |n|^2), one bit a stage
  for (genvar t = 0; t < NQ_W; t++) begin : g_ndiv
    logic [NREM_W-1:0] r_in [3];
    logic [NQ_W-1:0]   q_in [3];
    logic [SUM_W-1:0]  d_in;
    logic [NREM_W-1:0] r_sub [3];
    logic              ge [3];

    if (t == 0) begin : g_first
      assign d_in = s5_sum;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i] = NREM_W'(s5_sq[i]);
        assign q_in[i] = '0;
      end
    end else begin : g_rest
      assign d_in = nd_d[t];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i] = nd_r[t][i];
        assign q_in[i] = nd_q[t][i];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = r_in[i] >= NREM_W'(d_in);
        r_sub[i] = ge[i] ? r_in[i] - NREM_W'(d_in) : r_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd_d[t+1] <= d_in;
        for (int i = 0; i < 3; i++) begin
          nd_r[t+1][i] <= {r_sub[i][NREM_W-2:0], 1'b0};
          nd_q[t+1][i] <= {q_in[i][NQ_W-2:0], ge[i]};
        end
      end
    end
  end

  // integer square root of the quotient, one result bit a stage
  for (genvar t = 0; t < RT_W; t++) begin : g_sqrt
    localparam int K = RT_W - 1 - t;
    logic [NQ_W-1:0]  rem_in [3];
    logic [RT_W-1:0]  root_in [3];
    logic [SQT_W-1:0] term [3];
    logic             ge [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (t == 0) begin : g_first
        assign rem_in[i]  = nd_q[NQ_W][i];
        assign root_in[i] = '0;
      end else begin : g_rest
        assign rem_in[i]  = rt_rem[t][i];
        assign root_in[i] = rt_root[t][i];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        term[i] = (SQT_W'(root_in[i]) << (K + 1)) | (SQT_W'(1) << (2 * K));
        ge[i]   = SQT_W'(rem_in[i]) >= term[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rt_rem[t+1][i]  <= ge[i] ? rem_in[i] - term[i][NQ_W-1:0] : rem_in[i];
          rt_root[t+1][i] <= ge[i] ? root_in[i] | (RT_W'(1) << K) : root_in[i];
        end
      end
    end
  end

  // coefficient divider: |n_i| * 2^(2*FRAC_W) / |dot|, COORD_W quotient bits
  for (genvar t = 0; t < COORD_W; t++) begin : g_cdiv
    localparam int K = COORD_W - 1 - t;
    logic [CDIV_W-1:0]  r_in [3];
    logic [COORD_W-1:0] q_in [3];
    logic [DMAG_W-1:0]  d_in;
    logic [2:0]         ovf_in, nneg_in;
    logic               dneg_in;
    logic [CDIV_W-1:0]  dsh;
    logic               ge [3];

    if (t == 0) begin : g_first
      assign d_in    = s5_dmag;
      assign nneg_in = s5_nneg;
      assign dneg_in = s5_dneg;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i]   = CDIV_W'(s5_nmag[i]) << (2 * FRAC_W);
        assign q_in[i]   = '0;
        // quotient would need more than COORD_W bits
        assign ovf_in[i] = r_in[i] >= (CDIV_W'(s5_dmag) << COORD_W);
      end
    end else begin : g_rest
      assign d_in    = cd_d[t];
      assign nneg_in = cd_nneg[t];
      assign dneg_in = cd_dneg[t];
      assign ovf_in  = cd_ovf[t];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i] = cd_r[t][i];
        assign q_in[i] = cd_q[t][i];
      end
    end

    assign dsh = CDIV_W'(d_in) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) ge[i] = r_in[i] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_d[t+1]    <= d_in;
        cd_nneg[t+1] <= nneg_in;
        cd_dneg[t+1] <= dneg_in;
        cd_ovf[t+1]  <= ovf_in;
        for (int i = 0; i < 3; i++) begin
          cd_r[t+1][i] <= ge[i] ? r_in[i] - dsh : r_in[i];
          cd_q[t+1][i] <= ge[i] ? q_in[i] | (COORD_W'(1) << K) : q_in[i];
        end
      end
    end
  end

  // sign and saturation of the coefficients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = (cd_nneg[COORD_W][i] == cd_dneg[COORD_W])
             && (cd_ovf[COORD_W][i] || (cd_q[COORD_W][i] != '0));
      lim[i]  = cneg[i] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      qv[i]   = (cd_ovf[COORD_W][i] || (cd_q[COORD_W][i] > lim[i])) ? lim[i]
                                                                    : cd_q[COORD_W][i];
      cf_new[i] = cneg[i] ? -qv[i] : qv[i];
    end
  end

  // delay the coefficients to line up with the normal
  always_ff @(posedge clk) begin
    if (en) begin
      cf_dly[0] <= cf_new;
      for (int j = 1; j < CF_LEN; j++) cf_dly[j] <= cf_dly[j-1];
    end
  end

  // sideband delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      sd_vld <= '0;
    end else if (en) begin
      sd_vld <= {sd_vld[SD_LEN-1:1], vld[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_nneg[1] <= s5_nneg;
      sd_coll[1] <= s5_coll;
      sd_dotz[1] <= s5_dotz;
      for (int j = 2; j <= SD_LEN; j++) begin
        sd_nneg[j] <= sd_nneg[j-1];
        sd_coll[j] <= sd_coll[j-1];
        sd_dotz[j] <= sd_dotz[j-1];
      end
    end
  end

  // result assembly
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm[i]   = NORM_W'(rt_root[RT_W][i]);
      nout[i] = sd_coll[SD_LEN] ? '0 : (sd_nneg[SD_LEN][i] ? -nm[i] : nm[i]);
      cout[i] = (sd_coll[SD_LEN] || sd_dotz[SD_LEN]) ? '0 : cf_dly[CF_LEN-1][i];
    end
    if (sd_coll[SD_LEN])      st = ST_COLLINEAR;
    else if (sd_dotz[SD_LEN]) st = ST_ORIGIN;
    else                      st = ST_OK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      plane.valid <= 1'b0;
    end else if (en) begin
      plane.valid <= sd_vld[SD_LEN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plane.coef_a <= cout[0];
      plane.coef_b <= cout[1];
      plane.coef_c <= cout[2];
      plane.norm_x <= nout[0];
      plane.norm_y <= nout[1];
      plane.norm_z <= nout[2];
      plane.status <= st;
    end
  end

endmodule

// ===== rtl/plane_from_three_points.sv =====
// Plane coefficients and unit normal from three points, fully pipelined.
// Throughput: one beat per cycle while the output takes results; the
// bit-per-stage dividers and root set the depth.
// A 4-entry queue lets the front end take beats during an output stall until it fills.
// Reset (rst, synchronous) clears all valid bits and queue pointers; no clearing pass.
// Depends on pf3p_pkg, pf3p_in_if, pf3p_out_if, pf3p_front, pf3p_fifo, pf3p_back.
module plane_from_three_points import pf3p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pf3p_in_if.sink    pts,
  pf3p_out_if.source plane
);

  logic  q_push, q_full, q_pop, q_nonempty;
  item_t q_wdata, q_rdata;

  // front end: difference, cross product, classify
  pf3p_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pts    (pts),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wdata)
  );

  // decoupling queue
  pf3p_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  // back end: divide, root, saturate
  pf3p_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_rdata),
    .q_pop      (q_pop),
    .plane      (plane)
  );

endmodule
